[hw/rtl/fpsqrt_pkg.sv]
// Package for the fixed-point square root unit: pipeline word, stage op codes,
// stage schedule and the per-stage datapath function.
// No dependencies.
package fpsqrt_pkg;

    localparam int NUM_STAGES = 51;
    localparam logic [63:0] ONE_U163 = 64'h8000_0000_0000_0000;
    localparam logic [31:0] SQRT_HALF_U032 = 32'd3037000500;
    localparam logic [31:0] ONE_S16_15 = 32'd32768;

    typedef enum logic [4:0] {
        OP_LZC, OP_NORM,
        OP_C_M1, OP_C_A1, OP_C_M2, OP_C_A2, OP_ABS, OP_C_M3, OP_C_A4, OP_C_A5,
        OP_F_M1, OP_F_A1, OP_F_M2, OP_F_A2, OP_F_A3, OP_F_M3, OP_F_A5, OP_F_A6,
        OP_F_A7, OP_T_SH, OP_T_M2, OP_T_FIN
    } op_t;

    typedef struct packed {
        logic        sp;
        logic [23:0] spv;
        logic [5:0]  n;
        logic [31:0] x;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] z;
        logic [63:0] q0;
        logic [63:0] q1;
        logic [63:0] q2;
        logic [63:0] q3;
        logic        neg;
    } dat_t;

    localparam op_t OP_TABLE [NUM_STAGES] = '{
        OP_LZC, OP_NORM,
        OP_C_M1, OP_C_A1, OP_C_M2, OP_C_A2, OP_ABS, OP_C_M3, OP_C_A4, OP_C_A5,
        OP_C_M1, OP_C_A1, OP_C_M2, OP_C_A2, OP_ABS, OP_C_M3, OP_C_A4, OP_C_A5,
        OP_C_M1, OP_C_A1, OP_C_M2, OP_C_A2, OP_ABS, OP_C_M3, OP_C_A4, OP_C_A5,
        OP_F_M1, OP_F_A1, OP_F_M2, OP_F_A2, OP_F_A3, OP_ABS, OP_F_M3, OP_F_A5,
        OP_F_A6, OP_F_A7,
        OP_F_M1, OP_F_A1, OP_F_M2, OP_F_A2, OP_F_A3, OP_ABS, OP_F_M3, OP_F_A5,
        OP_F_A6, OP_F_A7,
        OP_F_M1, OP_F_A1, OP_T_SH, OP_T_M2, OP_T_FIN
    };

    // 32x32 product
    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // combine low/high partial products of a 64x32 multiply, rounded at bit 31
    function automatic logic [63:0] mulfin(input logic [63:0] lo, input logic [63:0] hi);
        return hi + (lo >> 32) + 64'(lo[31]);
    endfunction

    function automatic dat_t step(input op_t op, input dat_t din);
        dat_t        d;
        logic [31:0] h32;
        logic [31:0] h32b;
        logic [63:0] h64;
        logic [63:0] acc;
        logic [63:0] mid;
        logic [5:0]  cnt;
        d = din;
        h32 = {1'b0, d.r[63:33]};
        h32b = d.r[32:1];
        h64 = d.r >> 1;
        acc = '0;
        mid = '0;
        cnt = 6'd32;
        case (op)
            OP_LZC: begin
                for (int i = 0; i < 32; i++) begin
                    if (d.a[i]) cnt = 6'(31 - i);
                end
                d.n = cnt;
                d.sp = (d.a[31:0] == '0) || (d.a[31:0] == ONE_S16_15);
                d.spv = d.a[23:0];
            end
            OP_NORM: begin
                d.x = d.a[31:0] << d.n;
                d.r = {2'b0, d.x[30:1], 32'h0};
            end
            OP_C_M1: d.q0 = mul32(d.x, d.r[63:32]);
            OP_C_A1: d.a = {d.x, 32'h0} - (d.q0 >> 1);
            OP_C_M2: begin
                d.q0 = mul32(d.a[31:0], h32);
                d.q1 = mul32(d.a[63:32], h32);
            end
            OP_C_A2: d.a = d.a - mulfin(d.q0, d.q1);
            OP_ABS: begin
                acc = d.a - ONE_U163;
                d.neg = acc[63];
                d.z = acc[63] ? (64'd0 - acc) : acc;
            end
            OP_C_M3: begin
                d.q0 = mul32(d.z[31:0], h32);
                d.q1 = mul32(d.z[63:32], h32);
            end
            OP_C_A4: d.z = d.z - mulfin(d.q0, d.q1);
            OP_C_A5: begin
                acc = d.neg ? (64'd0 - d.z) : d.z;
                d.z = (acc << 1) + {d.r[63:32], 32'h0};
                d.r = d.z;
            end
            OP_F_M1: begin
                d.q0 = mul32(d.r[31:0], d.x);
                d.q1 = mul32(d.r[63:32], d.x);
            end
            OP_F_A1: d.a = {d.x, 32'h0} - (mulfin(d.q0, d.q1) >> 1);
            OP_F_M2: begin
                d.q0 = mul32(d.a[31:0], h64[31:0]);
                d.q1 = mul32(d.a[63:32], h64[31:0]);
                d.q2 = mul32(d.a[31:0], h64[63:32]);
                d.q3 = mul32(d.a[63:32], h64[63:32]);
            end
            OP_F_A2: begin
                acc = d.q1 + 64'(d.q0[31]);
                mid = d.q2 + {32'h0, acc[31:0]};
                d.q1 = acc;
                d.q2 = mid;
            end
            OP_F_A3: begin
                acc = (d.q1 >> 32) + (d.q2 >> 32) + 64'(d.q2[31]) + d.q3;
                d.a = d.a - acc;
            end
            OP_F_M3: begin
                d.q0 = mul32(d.z[31:0], h32);
                d.q1 = mul32(d.z[63:32], h32);
                d.q2 = mul32(d.z[31:0], h32b);
                d.q3 = mul32(d.z[63:32], h32b);
            end
            OP_F_A5: d.a = mulfin(d.q0, d.q1) + (mulfin(d.q2, d.q3) >> 32);
            OP_F_A6: d.z = d.z - d.a;
            OP_F_A7: begin
                acc = d.neg ? (64'd0 - d.z) : d.z;
                d.z = (acc << 1) + d.r;
                d.r = d.z;
            end
            OP_T_SH: d.a = d.a >> (6'(d.n[5:1]) + 6'd8);
            OP_T_M2: begin
                d.q0 = mul32(d.a[31:0], SQRT_HALF_U032);
                d.q1 = mul32(d.a[63:32], SQRT_HALF_U032);
            end
            OP_T_FIN: begin
                acc = d.n[0] ? mulfin(d.q0, d.q1) : d.a;
                d.z = d.sp ? {40'h0, d.spv} : {40'h0, acc[55:32]};
            end
            default: d = din;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/fixed_point_square_root_unit.sv]
// Fixed-point square root unit, s16.15 in, u9.15 out (reciprocal-root Newton pipeline).
// Depends on fpsqrt_pkg.
//
// channel  | dir | tdata
// s_       | in  | [31:0] operand_bits (signed)
// m_       | out | [23:0] root_bits
//
// One request per cycle unless m_tready stalls the pipeline; one stage per entry of OP_TABLE.
// Each stage holds at most one 32x32 multiply bank or one wide add.
// Reset clears only the stage valid bits.
// A stall on m_tready freezes the whole pipeline; s_tready drops with it.
module fixed_point_square_root_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic signed [31:0] s_tdata,   // [31:0] operand_bits
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata    // [23:0] root_bits
);
    import fpsqrt_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    dat_t                  st_reg  [NUM_STAGES];
    dat_t                  st_next [NUM_STAGES];
    dat_t                  in_dat;
    logic                  adv;

    assign adv      = !vld_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = st_reg[NUM_STAGES-1].z[23:0];

    always_comb begin
        in_dat = '0;
        in_dat.a = {32'h0, (s_tdata[31] ? 32'h0 : s_tdata)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_comb st_next[k] = step(OP_TABLE[k], in_dat);
        end else begin : g_rest
            always_comb st_next[k] = step(OP_TABLE[k], st_reg[k-1]);
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

endmodule
